[rtl/bli_pkg.sv]
`timescale 1ns / 1ps

package bli_pkg;

  localparam int INDEX_BITS_DEF = 24;
  localparam int LAYER_W        = 5;
  localparam int CFG_DATA_W     = 5;
  localparam int CFG_IDX_W      = 4;
  localparam int ZM1_W          = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_DEGREE      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAYER_COUNT = 4'd1;

  localparam logic [CFG_DATA_W-1:0] DEGREE_RST      = 5'd3;
  localparam logic [CFG_DATA_W-1:0] LAYER_COUNT_RST = 5'd10;
  localparam logic [CFG_DATA_W-1:0] DEGREE_MIN      = 5'd3;

  typedef struct packed {
    logic               found;
    logic [LAYER_W-1:0] layer;
  } walk_stat_t;

endpackage

[rtl/bli_if.sv]
`timescale 1ns / 1ps

interface bli_in_if #(
  parameter int INDEX_BITS = bli_pkg::INDEX_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [INDEX_BITS-1:0] node_index;

  modport source (output valid, output node_index, input ready);
  modport sink   (input valid, input node_index, output ready);
endinterface

interface bli_out_if #(
  parameter int INDEX_BITS = bli_pkg::INDEX_BITS_DEF
);
  logic                           valid;
  logic                           ready;
  logic [bli_pkg::LAYER_W-1:0]    layer;
  logic [INDEX_BITS-1:0]          layer_position;
  logic [INDEX_BITS-1:0]          parent_index;
  logic [INDEX_BITS-1:0]          first_child_index;
  logic                           on_boundary;
  logic                           is_root;
  logic [INDEX_BITS-1:0]          total_nodes;
  logic                           out_of_range;
  logic                           child_overflow;

  modport source (output valid, output layer, output layer_position, output parent_index,
                  output first_child_index, output on_boundary, output is_root,
                  output total_nodes, output out_of_range, output child_overflow,
                  input ready);
  modport sink   (input valid, input layer, input layer_position, input parent_index,
                  input first_child_index, input on_boundary, input is_root,
                  input total_nodes, input out_of_range, input child_overflow,
                  output ready);
endinterface

interface bli_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [bli_pkg::CFG_IDX_W-1:0]    index;
  logic [bli_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/bethe_lattice_node_indexer.sv]
`timescale 1ns / 1ps

// Cayley tree node indexer. One node index is taken when in_ch.ready is high; the block then
// walks the layers one per cycle, divides the in-layer offset by degree-1 with a restoring
// divider at one quotient bit per cycle (skipped for the root and out-of-range indices), and
// loads the result register from the finish state once the output register is free.
// in_ch.ready stays low from acceptance until that load; a finished result may wait in the
// output register while the next word is taken. Config writes are always accepted and must
// come only while the block is idle.

module bethe_lattice_node_indexer #(
  parameter int INDEX_BITS = bli_pkg::INDEX_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  bli_in_if.sink        in_ch,
  bli_out_if.source     out_ch,
  bli_cfg_if.sink       cfg_ch
);

  localparam int WW = INDEX_BITS + 2;
  localparam int CS = WW + 6;
  localparam int PW = INDEX_BITS + bli_pkg::ZM1_W;
  localparam logic [INDEX_BITS-1:0] IDX_MAX = {INDEX_BITS{1'b1}};

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state_r, state_nxt;

  logic [bli_pkg::CFG_DATA_W-1:0] degree_r, lcnt_r;
  logic [bli_pkg::ZM1_W-1:0]      zm1;

  logic [INDEX_BITS-1:0] idx_r, off_r;
  logic [PW-1:0]         prod_r;

  logic                          in_acc, out_free, root;
  logic                          walk_done, div_go, div_done;
  bli_pkg::walk_stat_t           wstat;
  logic [INDEX_BITS-1:0]         w_lstart, w_pstart, quo;
  logic [WW-1:0]                 w_lsize, w_total;
  logic [INDEX_BITS-1:0]         walk_idx, dividend;

  logic [CS-1:0]                 child_sum;
  logic                          ovf;
  logic [INDEX_BITS-1:0]         total_sat;

  logic                          out_valid_r;
  logic [bli_pkg::LAYER_W-1:0]   layer_r;
  logic [INDEX_BITS-1:0]         pos_r, parent_r, child_r, total_r;
  logic                          bnd_r, root_r, oor_r, ovf_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_r <= bli_pkg::DEGREE_RST;
      lcnt_r   <= bli_pkg::LAYER_COUNT_RST;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == bli_pkg::CFG_DEGREE) begin
        degree_r <= cfg_ch.data;
      end else if (cfg_ch.index == bli_pkg::CFG_LAYER_COUNT) begin
        lcnt_r <= cfg_ch.data;
      end
    end
  end

  assign zm1 = ((degree_r < bli_pkg::DEGREE_MIN) ? bli_pkg::DEGREE_MIN : degree_r) - 1'b1;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign root        = (idx_r == '0);
  assign walk_idx    = (state_r == S_IDLE) ? in_ch.node_index : idx_r;
  assign dividend    = idx_r - w_lstart;
  assign div_go      = (state_r == S_WALK) && walk_done && wstat.found && !root;

  bli_walk #(.INDEX_BITS(INDEX_BITS)) u_walk (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (in_acc),
    .idx    (walk_idx),
    .zm1    (zm1),
    .lcnt   (lcnt_r),
    .done   (walk_done),
    .stat   (wstat),
    .lstart (w_lstart),
    .lsize  (w_lsize),
    .pstart (w_pstart),
    .total  (w_total)
  );

  bli_div #(.INDEX_BITS(INDEX_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go),
    .dividend (dividend),
    .divisor  (zm1),
    .done     (div_done),
    .quotient (quo)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_WALK;
      S_WALK: begin
        if (walk_done) state_nxt = div_go ? S_DIV : S_FIN;
      end
      S_DIV:  if (div_done) state_nxt = S_FIN;
      S_FIN:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) idx_r <= in_ch.node_index;
    if (div_go) off_r <= dividend;
    if (state_r == S_DIV) prod_r <= {{bli_pkg::ZM1_W{1'b0}}, off_r} * PW'(zm1);
  end

  assign child_sum = CS'(w_lstart) + CS'(w_lsize) + CS'(prod_r);
  assign ovf       = wstat.found && !root && (child_sum > CS'(IDX_MAX));
  assign total_sat = (w_total > WW'(IDX_MAX)) ? IDX_MAX : w_total[INDEX_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_FIN && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FIN && out_free) begin
      total_r <= total_sat;
      root_r  <= root;
      ovf_r   <= ovf;
      if (root) begin
        layer_r  <= '0;
        pos_r    <= '0;
        parent_r <= '0;
        child_r  <= INDEX_BITS'(1);
        bnd_r    <= (lcnt_r == '0);
        oor_r    <= 1'b0;
      end else if (wstat.found) begin
        layer_r  <= wstat.layer;
        pos_r    <= off_r + 1'b1;
        parent_r <= (wstat.layer == bli_pkg::LAYER_W'(1)) ? '0 : (w_pstart + quo);
        child_r  <= ovf ? '0 : child_sum[INDEX_BITS-1:0];
        bnd_r    <= (wstat.layer == lcnt_r);
        oor_r    <= 1'b0;
      end else begin
        layer_r  <= '0;
        pos_r    <= '0;
        parent_r <= '0;
        child_r  <= '0;
        bnd_r    <= 1'b0;
        oor_r    <= 1'b1;
      end
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.layer             = layer_r;
  assign out_ch.layer_position    = pos_r;
  assign out_ch.parent_index      = parent_r;
  assign out_ch.first_child_index = child_r;
  assign out_ch.on_boundary       = bnd_r;
  assign out_ch.is_root           = root_r;
  assign out_ch.total_nodes       = total_r;
  assign out_ch.out_of_range      = oor_r;
  assign out_ch.child_overflow    = ovf_r;

  a_oor_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && oor_r) |-> (layer_r == '0 && child_r == '0 && !ovf_r && !root_r))
    else $error("out-of-range word carries node fields");

  a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && ovf_r) |-> (child_r == '0 && !oor_r))
    else $error("child overflow with nonzero child index");

  a_root_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && root_r) |-> (layer_r == '0 && pos_r == '0 && child_r == INDEX_BITS'(1)))
    else $error("root word has wrong fields");

  a_div_entry: assert property (@(posedge clk) disable iff (!rst_n)
    div_go |=> (state_r == S_DIV))
    else $error("divider started without entering divide state");

endmodule

[rtl/bli_walk.sv]
`timescale 1ns / 1ps

module bli_walk #(
  parameter int INDEX_BITS = bli_pkg::INDEX_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [INDEX_BITS-1:0]         idx,
  input  logic [bli_pkg::ZM1_W-1:0]     zm1,
  input  logic [bli_pkg::LAYER_W-1:0]   lcnt,
  output logic                          done,
  output bli_pkg::walk_stat_t           stat,
  output logic [INDEX_BITS-1:0]         lstart,
  output logic [INDEX_BITS+1:0]         lsize,
  output logic [INDEX_BITS-1:0]         pstart,
  output logic [INDEX_BITS+1:0]         total
);

  localparam int WW = INDEX_BITS + 2;
  localparam int PW = WW + bli_pkg::ZM1_W;
  localparam logic [WW-1:0] CAP = {1'b1, {(WW-1){1'b0}}};

  logic                         busy_r;
  logic [bli_pkg::LAYER_W:0]    k_r;
  logic [WW-1:0]                prev_r, start_r, size_r;
  logic                         found_r;
  logic [bli_pkg::LAYER_W-1:0]  layer_r;
  logic [INDEX_BITS-1:0]        lstart_r, pstart_r;
  logic [WW-1:0]                lsize_r;

  logic [WW:0]   sum_ss;
  logic [WW-1:0] start_sat, size_sat;
  logic [PW-1:0] prod;
  logic          hit, last;

  assign sum_ss    = {1'b0, start_r} + {1'b0, size_r};
  assign start_sat = (sum_ss > {1'b0, CAP}) ? CAP : sum_ss[WW-1:0];
  assign prod      = {{bli_pkg::ZM1_W{1'b0}}, size_r} * PW'(zm1);
  assign size_sat  = (prod > PW'(CAP)) ? CAP : prod[WW-1:0];
  assign hit       = !found_r && ({3'b000, idx} < sum_ss);
  assign last      = k_r > {1'b0, lcnt};

  assign done   = busy_r && last;
  assign stat   = '{found: found_r, layer: layer_r};
  assign lstart = lstart_r;
  assign lsize  = lsize_r;
  assign pstart = pstart_r;
  assign total  = start_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (done) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      k_r      <= (bli_pkg::LAYER_W+1)'(1);
      prev_r   <= '0;
      start_r  <= WW'(1);
      size_r   <= WW'(zm1) + WW'(1);
      found_r  <= (idx == '0);
      layer_r  <= '0;
      lstart_r <= '0;
      lsize_r  <= '0;
      pstart_r <= '0;
    end else if (busy_r && !last) begin
      if (hit) begin
        found_r  <= 1'b1;
        layer_r  <= k_r[bli_pkg::LAYER_W-1:0];
        lstart_r <= start_r[INDEX_BITS-1:0];
        lsize_r  <= size_r;
        pstart_r <= prev_r[INDEX_BITS-1:0];
      end
      k_r     <= k_r + 1'b1;
      prev_r  <= start_r;
      start_r <= start_sat;
      size_r  <= size_sat;
    end
  end

endmodule

[rtl/bli_div.sv]
`timescale 1ns / 1ps

module bli_div #(
  parameter int INDEX_BITS = bli_pkg::INDEX_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [INDEX_BITS-1:0]      dividend,
  input  logic [bli_pkg::ZM1_W-1:0]  divisor,
  output logic                       done,
  output logic [INDEX_BITS-1:0]      quotient
);

  localparam int CW = $clog2(INDEX_BITS + 1);
  localparam int RW = bli_pkg::ZM1_W + 1;

  logic                   busy_r, done_r;
  logic [CW-1:0]          cnt_r;
  logic [INDEX_BITS-1:0]  quo_r;
  logic [RW-1:0]          rem_r;

  logic [RW-1:0] trial;
  logic          ge;

  assign trial    = {rem_r[RW-2:0], quo_r[INDEX_BITS-1]};
  assign ge       = trial >= {1'b0, divisor};
  assign done     = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CW'(INDEX_BITS - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= '0;
      quo_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      quo_r <= {quo_r[INDEX_BITS-2:0], ge};
      rem_r <= ge ? (trial - {1'b0, divisor}) : trial;
    end
  end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  localparam int IDX_W = bli_pkg::INDEX_BITS_DEF;
  localparam int DATA_W = bli_pkg::CFG_DATA_W;
  localparam logic [bli_pkg::CFG_IDX_W-1:0] CFG_SPARE = 4'hF;
  localparam int LIMIT = 1500000;
  localparam int PHASES = 12;
  localparam int PHASE_WORDS = 160;

  typedef logic [63:0] wide_t;
  localparam wide_t IDX_MASK = (64'd1 << IDX_W) - 64'd1;
  localparam wide_t SAT_CAP = 64'd1 << 60;

  typedef struct packed {
    logic [bli_pkg::LAYER_W-1:0] layer;
    logic [IDX_W-1:0]            layer_position;
    logic [IDX_W-1:0]            parent_index;
    logic [IDX_W-1:0]            first_child_index;
    logic                        on_boundary;
    logic                        is_root;
    logic [IDX_W-1:0]            total_nodes;
    logic                        out_of_range;
    logic                        child_overflow;
  } node_info_t;

  class lattice_checker;
    logic [DATA_W-1:0] degree_q = bli_pkg::DEGREE_RST;
    logic [DATA_W-1:0] layers_q = bli_pkg::LAYER_COUNT_RST;
    node_info_t expected_q[$];
    int errors = 0;

    function void set_reg(logic [bli_pkg::CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
      if (idx == bli_pkg::CFG_DEGREE) degree_q = val;
      else if (idx == bli_pkg::CFG_LAYER_COUNT) layers_q = val;
    endfunction

    function wide_t cap_sum(wide_t a, wide_t b);
      wide_t r;
      r = a + b;
      return (r > SAT_CAP) ? SAT_CAP : r;
    endfunction

    function wide_t cap_prod(wide_t a, wide_t b);
      wide_t r;
      if (b == 0) return 0;
      if (a > SAT_CAP / b) return SAT_CAP;
      r = a * b;
      return (r > SAT_CAP) ? SAT_CAP : r;
    endfunction

    function wide_t eff_degree();
      return (degree_q < bli_pkg::DEGREE_MIN) ? wide_t'(bli_pkg::DEGREE_MIN) : wide_t'(degree_q);
    endfunction

    // first index of layer k; layer_start(L+1) is the node count
    function wide_t layer_start(int k);
      wide_t start, size;
      if (k == 0) return 0;
      start = 1;
      size = eff_degree();
      for (int j = 1; j < k; j++) begin
        start = cap_sum(start, size);
        size = cap_prod(size, eff_degree() - 1);
      end
      return start;
    endfunction

    function node_info_t locate_node(logic [IDX_W-1:0] idx);
      wide_t z, prev, start, size, layer, lstart, lsize, pstart, pos, parent, child, total;
      bit found, root, boundary, overflow;
      node_info_t r;
      z = eff_degree();
      prev = 0; start = 1; size = z;
      layer = 0; lstart = 0; lsize = 0; pstart = 0;
      pos = 0; parent = 0; child = 0;
      found = (idx == 0);
      root = found;
      boundary = 0;
      overflow = 0;
      for (int k = 1; k <= int'(layers_q); k++) begin
        if (!found && wide_t'(idx) < start + size) begin
          found = 1;
          layer = k;
          lstart = start;
          lsize = size;
          pstart = prev;
        end
        prev = start;
        start = cap_sum(start, size);
        size = cap_prod(size, z - 1);
      end
      total = start;
      if (root) begin
        child = 1;
        boundary = (layers_q == 0);
      end else if (found) begin
        pos = wide_t'(idx) - lstart + 1;
        if (layer == 1) parent = 0;
        else parent = (pstart - 1) + (pos + z - 2) / (z - 1);
        child = cap_sum(lstart, lsize) + (pos - 1) * (z - 1);
        boundary = (layer == wide_t'(layers_q));
      end
      if (found && child > IDX_MASK) begin
        overflow = 1;
        child = 0;
      end
      r.layer = layer[bli_pkg::LAYER_W-1:0];
      r.layer_position = pos[IDX_W-1:0];
      r.parent_index = parent[IDX_W-1:0];
      r.first_child_index = child[IDX_W-1:0];
      r.on_boundary = boundary;
      r.is_root = root;
      r.total_nodes = (total > IDX_MASK) ? IDX_MASK[IDX_W-1:0] : total[IDX_W-1:0];
      r.out_of_range = !found;
      r.child_overflow = overflow;
      return r;
    endfunction

    function void note_query(logic [IDX_W-1:0] idx);
      expected_q.push_back(locate_node(idx));
    endfunction

    function void match_field(string name, wide_t exp_v, wide_t act_v);
      if (act_v !== exp_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_answer(node_info_t act);
      node_info_t e;
      if (expected_q.size() == 0) begin
        $error("result word with no query outstanding");
        errors++;
        return;
      end
      e = expected_q.pop_front();
      match_field("layer", e.layer, act.layer);
      match_field("layer_position", e.layer_position, act.layer_position);
      match_field("parent_index", e.parent_index, act.parent_index);
      match_field("first_child_index", e.first_child_index, act.first_child_index);
      match_field("on_boundary", e.on_boundary, act.on_boundary);
      match_field("is_root", e.is_root, act.is_root);
      match_field("total_nodes", e.total_nodes, act.total_nodes);
      match_field("out_of_range", e.out_of_range, act.out_of_range);
      match_field("child_overflow", e.child_overflow, act.child_overflow);
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  bli_in_if  #(.INDEX_BITS(IDX_W)) in_ch ();
  bli_out_if #(.INDEX_BITS(IDX_W)) out_ch ();
  bli_cfg_if cfg_ch ();

  bethe_lattice_node_indexer #(.INDEX_BITS(IDX_W)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  lattice_checker chk = new();

  int cycles = 0;
  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int stall_left = 0;
  bit quiet = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) chk.note_query(in_ch.node_index);
      if (out_ch.valid && out_ch.ready)
        chk.check_answer('{out_ch.layer, out_ch.layer_position, out_ch.parent_index,
                           out_ch.first_child_index, out_ch.on_boundary, out_ch.is_root,
                           out_ch.total_nodes, out_ch.out_of_range, out_ch.child_overflow});
    end
  end

  // result-side backpressure in bursts
  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 99) < out_stall_pct) begin
      stall_left = $urandom_range(0, 13);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic run_query(logic [IDX_W-1:0] idx);
    in_ch.valid <= 1'b1;
    in_ch.node_index <= idx;
    do @(posedge clk); while (!in_ch.ready);
    if (!quiet && $urandom_range(0, 99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic wait_drain();
    do @(posedge clk); while (chk.outstanding() > 0);
  endtask

  task automatic program_lattice(logic [DATA_W-1:0] deg, logic [DATA_W-1:0] lay,
                                 bit stray);
    logic [DATA_W-1:0] junk;
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= bli_pkg::CFG_DEGREE;
    cfg_ch.data <= deg;
    do @(posedge clk); while (!cfg_ch.ready);
    chk.set_reg(bli_pkg::CFG_DEGREE, deg);
    cfg_ch.index <= bli_pkg::CFG_LAYER_COUNT;
    cfg_ch.data <= lay;
    do @(posedge clk); while (!cfg_ch.ready);
    chk.set_reg(bli_pkg::CFG_LAYER_COUNT, lay);
    if (stray) begin
      // unmapped register: must be ignored
      junk = $urandom_range(0, 31);
      cfg_ch.index <= CFG_SPARE;
      cfg_ch.data <= junk;
      do @(posedge clk); while (!cfg_ch.ready);
      chk.set_reg(CFG_SPARE, junk);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [IDX_W-1:0] pick_node();
    wide_t total, lo, span, off, pick;
    int r, k, kmax;
    total = chk.layer_start(int'(chk.layers_q) + 1);
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (r < 8) return '1;
    if (r < 20) return IDX_W'({$urandom, $urandom});
    if (r < 30) begin
      pick = total - 1 + $urandom_range(0, 2);
      if (pick > IDX_MASK) return IDX_W'({$urandom, $urandom});
      return pick[IDX_W-1:0];
    end
    if (chk.layers_q == 0) return IDX_W'($urandom_range(0, 3));
    kmax = 1;
    while (kmax < int'(chk.layers_q) && chk.layer_start(kmax + 1) <= IDX_MASK) kmax++;
    k = $urandom_range(1, kmax);
    lo = chk.layer_start(k);
    span = chk.layer_start(k + 1) - lo;
    if (span == 0) span = 1;
    case ($urandom_range(0, 3))
      0: off = 0;
      1: off = span - 1;
      default: off = {$urandom, $urandom} % span;
    endcase
    if (lo + off > IDX_MASK) off = {$urandom, $urandom} % (IDX_MASK - lo + 1);
    pick = lo + off;
    return pick[IDX_W-1:0];
  endfunction

  int deg_plan[PHASES] = '{3, 3, 16, 16, 0, 2, 31, 1, 4, -1, -1, 5};
  int lay_plan[PHASES] = '{10, 24, 1, 24, 0, 5, 31, 3, 12, -1, -1, 8};

  initial begin
    logic [IDX_W-1:0] directed[$];
    logic [DATA_W-1:0] deg, lay;
    wide_t total;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.node_index <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= bli_pkg::CFG_DEGREE;
    cfg_ch.data <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: root, first layers, layer edges, last node, past the end, bit patterns
    total = chk.layer_start(int'(chk.layers_q) + 1);
    directed = '{0, 1, 2, 3, 4, 9, 10};
    directed.push_back(IDX_W'(chk.layer_start(2) - 1));
    directed.push_back(IDX_W'(chk.layer_start(int'(chk.layers_q))));
    directed.push_back(IDX_W'(total - 1));
    directed.push_back(IDX_W'(total));
    directed.push_back(IDX_W'(total + 1));
    directed.push_back('1);
    directed.push_back(24'hAAAAAA);
    directed.push_back(24'h555555);
    directed.push_back(24'h7FFFFF);
    in_idle_pct = 20;
    out_stall_pct = 10;
    foreach (directed[i]) run_query(directed[i]);

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        in_ch.valid <= 1'b0;
        wait_drain();
        deg = (deg_plan[p] < 0) ? DATA_W'($urandom_range(0, 31)) : DATA_W'(deg_plan[p]);
        lay = (lay_plan[p] < 0) ? DATA_W'($urandom_range(0, 31)) : DATA_W'(lay_plan[p]);
        program_lattice(deg, lay, p == 4);
      end
      quiet = (p == PHASES - 1);
      in_idle_pct = (p % 3 == 2) ? 0 : $urandom_range(5, 50);
      out_stall_pct = (p % 4 == 3) ? 0 : $urandom_range(5, 40);
      for (int n = 0; n < PHASE_WORDS; n++) run_query(pick_node());
    end
    in_ch.valid <= 1'b0;
    wait_drain();
    repeat (80) @(posedge clk);
    if (chk.errors == 0 && chk.outstanding() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
